// ----- hdl/duv_pkg.sv -----
// Shared types and constants for the direction unit vector pipeline.
package duv_pkg;
  localparam int CoordW = 32;
  localparam int DeltaW = 33;
  localparam int MagW   = 32;
  localparam int SqW    = 64;
  localparam int SumW   = 66;
  localparam int RootW  = 34;
  localparam int DistW  = 33;

  typedef struct packed {
    logic signed [CoordW-1:0] from_x;
    logic signed [CoordW-1:0] from_y;
    logic signed [CoordW-1:0] from_z;
    logic signed [CoordW-1:0] to_x;
    logic signed [CoordW-1:0] to_y;
    logic signed [CoordW-1:0] to_z;
  } duv_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] unit_x;
    logic signed [CoordW-1:0] unit_y;
    logic signed [CoordW-1:0] unit_z;
    logic [DistW-1:0]         distance;
    logic                     zero_length;
  } duv_out_t;
endpackage

// ----- hdl/duv_if.sv -----
// Valid/ready channel interface carrying one payload item.
interface duv_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/duv_sqrt.sv -----
// Pipelined restoring square root, one result bit per stage, carrying delta sign and magnitude.
module duv_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [duv_pkg::SumW-1:0]  in_sum,
  input  logic [3*duv_pkg::MagW-1:0] in_mag,
  input  logic [2:0]                in_neg,
  output logic                      out_valid,
  output logic [duv_pkg::RootW-1:0] out_root,
  output logic [3*duv_pkg::MagW-1:0] out_mag,
  output logic [2:0]                out_neg,
  output logic                      out_zero
);
  import duv_pkg::*;
  // one stage per digit pair of the sum
  localparam int N = SumW / 2;

  logic [N:0]            v;
  logic [SumW+1:0]       rem [N+1];
  logic [SumW-1:0]       rad [N+1];
  logic [RootW-1:0]      root [N+1];
  logic [3*MagW-1:0]     mg [N+1];
  logic [2:0]            ng [N+1];
  logic                  zr [N+1];

  assign v[0]    = in_valid;
  assign rem[0]  = '0;
  assign rad[0]  = in_sum;
  assign root[0] = '0;
  assign mg[0]   = in_mag;
  assign ng[0]   = in_neg;
  assign zr[0]   = (in_sum == '0);

  // one digit pair per stage: trial subtract of 4r+1
  for (genvar s = 0; s < N; s++) begin : g_st
    logic [SumW+1:0] cur, trial;
    always_comb begin
      cur   = {rem[s][SumW-1:0], rad[s][SumW-1 -: 2]};
      trial = {root[s], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) v[s+1] <= 1'b0;
      else if (en) v[s+1] <= v[s];
      if (en) begin
        if (cur >= trial) begin
          rem[s+1]  <= cur - trial;
          root[s+1] <= {root[s][RootW-2:0], 1'b1};
        end else begin
          rem[s+1]  <= cur;
          root[s+1] <= {root[s][RootW-2:0], 1'b0};
        end
        rad[s+1] <= {rad[s][SumW-3:0], 2'b00};
        mg[s+1]  <= mg[s];
        ng[s+1]  <= ng[s];
        zr[s+1]  <= zr[s];
      end
    end
  end

  assign out_valid = v[N];
  assign out_root  = root[N];
  assign out_mag   = mg[N];
  assign out_neg   = ng[N];
  assign out_zero  = zr[N];

  a_zero_root: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_zero |-> out_root == '0) else $error("zero sum gave nonzero root");
endmodule

// ----- hdl/duv_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, for one component.
module duv_div #(
  parameter int FRAC = 30
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [duv_pkg::MagW-1:0]  in_mag,
  input  logic [duv_pkg::RootW-1:0] in_den,
  output logic                      out_valid,
  output logic [duv_pkg::MagW-1:0]  out_quo
);
  import duv_pkg::*;
  // quotient <= 2^FRAC, so FRAC+1 bits suffice
  localparam int QW = FRAC + 1;
  localparam int NW = MagW + FRAC;

  logic [QW:0]        v;
  logic [RootW:0]     rem [QW+1];
  logic [NW-1:0]      num [QW+1];
  logic [RootW-1:0]   den [QW+1];
  logic [QW-1:0]      quo [QW+1];

  assign v[0]   = in_valid;
  // top NW-QW bits preload the remainder; they are below den
  assign rem[0] = (RootW+1)'(in_mag >> (MagW - (NW - QW)));
  assign num[0] = {in_mag, {FRAC{1'b0}}} << (NW - QW);
  assign den[0] = in_den;
  assign quo[0] = '0;

  for (genvar s = 0; s < QW; s++) begin : g_st
    logic [RootW+1:0] cur;
    assign cur = {rem[s], num[s][NW-1]};
    always_ff @(posedge clk) begin
      if (rst) v[s+1] <= 1'b0;
      else if (en) v[s+1] <= v[s];
      if (en) begin
        if (cur >= {1'b0, den[s]} && den[s] != '0) begin
          rem[s+1] <= (RootW+1)'(cur - {1'b0, den[s]});
          quo[s+1] <= {quo[s][QW-2:0], 1'b1};
        end else begin
          rem[s+1] <= cur[RootW:0];
          quo[s+1] <= {quo[s][QW-2:0], 1'b0};
        end
        num[s+1] <= {num[s][NW-2:0], 1'b0};
        den[s+1] <= den[s];
      end
    end
  end

  assign out_valid = v[QW];
  assign out_quo   = MagW'(quo[QW]);
endmodule

// ----- hdl/direction_unit_vector_top.sv -----
// Top level: delta, squares, sum, square root and three dividers with an output register.
// Throughput: one item per cycle while the output register is not stalled. An item passes through
// the delta, square and sum stages, the bit-serial root and divider pipelines and the output register.
// The whole pipeline advances only when the output register can take an item.
// Synchronous active-high rst clears all valid bits; data registers are not reset.
module direction_unit_vector_top #(
  parameter int OUT_FRAC_BITS = 30
) (
  input logic clk,
  input logic rst,
  duv_if.sink   in_ch,
  duv_if.source out_ch
);
  import duv_pkg::*;

  logic en;
  logic v1, v2, v3;
  logic signed [DeltaW-1:0] dx, dy, dz;
  logic [MagW-1:0] m1 [3];
  logic [2:0] n1, n2, n3;
  logic [MagW-1:0] m2 [3];
  logic [SqW-1:0] sq [3];
  logic [SumW-1:0] sum3;
  logic [3*MagW-1:0] m3;
  logic sv;
  logic [RootW-1:0] root;
  logic [3*MagW-1:0] smag;
  logic [2:0] sneg;
  logic szero;
  logic [2:0] dv;
  logic [MagW-1:0] q [3];
  logic [RootW-1:0] droot [OUT_FRAC_BITS+2];
  logic [2:0] dneg [OUT_FRAC_BITS+2];
  logic dzr [OUT_FRAC_BITS+2];
  logic ov;
  duv_out_t ob;

  // pipeline moves when the output slot is empty or being taken
  assign en = !ov || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    dx = DeltaW'(in_ch.data.to_x) - DeltaW'(in_ch.data.from_x);
    dy = DeltaW'(in_ch.data.to_y) - DeltaW'(in_ch.data.from_y);
    dz = DeltaW'(in_ch.data.to_z) - DeltaW'(in_ch.data.from_z);
  end

  // stage 1: delta magnitudes and signs
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_ch.valid;
    if (en) begin
      m1[0] <= MagW'(dx[DeltaW-1] ? -dx : dx);
      m1[1] <= MagW'(dy[DeltaW-1] ? -dy : dy);
      m1[2] <= MagW'(dz[DeltaW-1] ? -dz : dz);
      n1 <= {dz[DeltaW-1], dy[DeltaW-1], dx[DeltaW-1]};
    end
  end

  // stage 2: squares, one 32x32 multiply each
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= m1[i] * m1[i];
        m2[i] <= m1[i];
      end
      n2 <= n1;
    end
  end

  // stage 3: sum of squares
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      sum3 <= SumW'(sq[0]) + SumW'(sq[1]) + SumW'(sq[2]);
      m3 <= {m2[2], m2[1], m2[0]};
      n3 <= n2;
    end
  end

  duv_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3), .in_sum(sum3), .in_mag(m3),
    .in_neg(n3), .out_valid(sv), .out_root(root), .out_mag(smag), .out_neg(sneg),
    .out_zero(szero)
  );

  for (genvar c = 0; c < 3; c++) begin : g_div
    duv_div #(.FRAC(OUT_FRAC_BITS)) u_div (
      .clk(clk), .rst(rst), .en(en), .in_valid(sv),
      .in_mag(smag[c*MagW +: MagW]), .in_den(root),
      .out_valid(dv[c]), .out_quo(q[c])
    );
  end

  // side band delayed to match the dividers
  assign droot[0] = root;
  assign dneg[0]  = sneg;
  assign dzr[0]   = szero;
  for (genvar s = 0; s < OUT_FRAC_BITS + 1; s++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        droot[s+1] <= droot[s];
        dneg[s+1]  <= dneg[s];
        dzr[s+1]   <= dzr[s];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (en) ov <= dv[0];
    if (en) begin
      ob.unit_x <= dneg[OUT_FRAC_BITS+1][0] ? -q[0] : q[0];
      ob.unit_y <= dneg[OUT_FRAC_BITS+1][1] ? -q[1] : q[1];
      ob.unit_z <= dneg[OUT_FRAC_BITS+1][2] ? -q[2] : q[2];
      ob.distance <= DistW'(droot[OUT_FRAC_BITS+1]);
      ob.zero_length <= dzr[OUT_FRAC_BITS+1];
    end
  end

  assign out_ch.valid = ov;
  assign out_ch.data  = ob;

  a_lanes: assert property (@(posedge clk) disable iff (rst)
    dv[0] == dv[1] && dv[1] == dv[2]) else $error("divider lanes out of step");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    ov && !out_ch.ready |=> ov && $stable(ob)) else $error("stalled output changed");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    ov && ob.zero_length |-> ob.distance == '0 && ob.unit_x == '0)
    else $error("zero length item not zero");
endmodule

// ----- test/testbench.sv -----
// Testbench for direction_unit_vector_top: directed and random point pairs checked against a predictor.
`timescale 1ns / 1ps
module testbench;
  import duv_pkg::*;

  localparam int FracBits = 30;
  localparam int Latency = 3 + 33 + (FracBits + 1) + 1;
  localparam int IdleLimit = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  duv_if #(.payload_t(duv_in_t))  in_ch  (clk);
  duv_if #(.payload_t(duv_out_t)) out_ch (clk);

  direction_unit_vector_top #(.OUT_FRAC_BITS(FracBits)) uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  duv_out_t direction_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit sender_gaps = 1'b1;
  bit receiver_gaps = 1'b1;

  // Truncating unit component of one delta against the length.
  function automatic logic signed [31:0] unit_of(logic signed [32:0] d, logic [33:0] len);
    logic [32:0] mag;
    logic [127:0] q;
    if (d == 0 || len == 0) return '0;
    mag = d[32] ? 33'(-d) : 33'(d);
    q = ({95'd0, mag} << FracBits) / {94'd0, len};
    return d[32] ? 32'(-q) : 32'(q);
  endfunction

  // Expected direction and distance for one pair of points.
  function automatic duv_out_t predict_direction(duv_in_t p);
    logic signed [32:0] dx, dy, dz;
    logic [65:0] sum;
    logic [67:0] trial;
    logic [33:0] root;
    duv_out_t r;
    dx = 33'(p.to_x) - 33'(p.from_x);
    dy = 33'(p.to_y) - 33'(p.from_y);
    dz = 33'(p.to_z) - 33'(p.from_z);
    sum = 66'(dx * dx) + 66'(dy * dy) + 66'(dz * dz);
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      trial = 68'(root | (34'd1 << b));
      if (trial * trial <= 68'(sum)) root = root | (34'd1 << b);
    end
    r.unit_x = unit_of(dx, root);
    r.unit_y = unit_of(dy, root);
    r.unit_z = unit_of(dz, root);
    r.distance = root[32:0];
    r.zero_length = (sum == 0);
    return r;
  endfunction

  // Send one item and queue its expectation on acceptance; valid stays up
  // between back-to-back items and drops only for a gap.
  task automatic send_points(duv_in_t p);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= p;
    do @(posedge clk); while (!in_ch.ready);
    direction_q.push_back(predict_direction(p));
    @(negedge clk);
  endtask

  function automatic logic [31:0] edge_coord();
    case ($urandom_range(0, 6))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'hffff_ffff;
      4: return 32'd1;
      5: return 32'($signed($urandom_range(0, 512)) - 256);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    duv_in_t p;
    p = '0; send_points(p);
    p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff}; send_points(p);
    p = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000}; send_points(p);
    p = '{32'h1234_5678, 32'hdead_beef, 32'h0000_0001,
          32'h1234_5678, 32'hdead_beef, 32'h0000_0001}; send_points(p);
    // single vector along each axis, with both signs on x
    p = '0; p.to_x = 32'h0001_0000; send_points(p);
    p = '0; p.to_y = 32'hffff_0000; send_points(p);
    p = '0; p.to_z = 32'h7fff_ffff; send_points(p);
    p = '0; p.to_x = 32'h8000_0000; send_points(p);
    p = '0; p.to_x = 32'd1; p.to_y = 32'd1; p.to_z = 32'd1; send_points(p);
    p = '0; p.from_x = 32'h8000_0000; p.to_x = 32'h7fff_ffff; p.to_y = 32'd1; send_points(p);
    p = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0, 32'h0}; send_points(p);
    p = '{32'h0, 32'h0, 32'h0, 32'h0003_0000, 32'h0004_0000, 32'h0}; send_points(p);
  endtask

  task automatic test_random();
    duv_in_t p;
    for (int i = 0; i < 770; i++) begin
      if (i % 200 == 150) sender_gaps = 1'b0;
      if (i % 200 == 0) sender_gaps = 1'b1;
      receiver_gaps = !((i % 300) >= 100 && (i % 300) < 160);
      if ($urandom_range(0, 3) == 0) begin
        p = '{edge_coord(), edge_coord(), edge_coord(),
              edge_coord(), edge_coord(), edge_coord()};
      end else begin
        p = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 9) == 0) p.from_x = p.to_x;
        if ($urandom_range(0, 19) == 0) p.to_x = 32'd0;
        if ($urandom_range(0, 9) == 0) {p.from_x, p.from_y, p.from_z} = '0;
        if ($urandom_range(0, 49) == 0) {p.to_x, p.to_y, p.to_z} = {p.from_x, p.from_y, p.from_z};
      end
      send_points(p);
    end
    receiver_gaps = 1'b1;
  endtask

  // Receiver stalls long enough for the pipeline to fill and push back.
  task automatic test_backpressure();
    duv_in_t p;
    hold_off = 1'b1;
    sender_gaps = 1'b0;
    for (int i = 0; i < 120; i++) begin
      p = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      send_points(p);
    end
    sender_gaps = 1'b1;
  endtask

  // Receiver: random stalls per item, and a long hold-off on request.
  initial begin
    int wait_n;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      wait_n = receiver_gaps ? $urandom_range(0, 10) : 0;
      if (wait_n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    duv_out_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (direction_q.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        exp_r = direction_q.pop_front();
        if (out_ch.data.unit_x !== exp_r.unit_x) begin
          $error("unit_x expected %0d got %0d", exp_r.unit_x, out_ch.data.unit_x); errors++;
        end
        if (out_ch.data.unit_y !== exp_r.unit_y) begin
          $error("unit_y expected %0d got %0d", exp_r.unit_y, out_ch.data.unit_y); errors++;
        end
        if (out_ch.data.unit_z !== exp_r.unit_z) begin
          $error("unit_z expected %0d got %0d", exp_r.unit_z, out_ch.data.unit_z); errors++;
        end
        if (out_ch.data.distance !== exp_r.distance) begin
          $error("distance expected %0d got %0d", exp_r.distance, out_ch.data.distance);
          errors++;
        end
        if (out_ch.data.zero_length !== exp_r.zero_length) begin
          $error("zero_length expected %0b got %0b", exp_r.zero_length,
                 out_ch.data.zero_length);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted item on either side.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("direction_unit_vector_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random();
    in_ch.valid <= 1'b0;
    while (direction_q.size() != 0) @(negedge clk);
    repeat (Latency + 10) @(negedge clk);
    if (errors == 0 && direction_q.size() == 0) begin
      $display("direction_unit_vector_top verification clean");
    end else begin
      $display("direction_unit_vector_top verification failed");
    end
    $finish;
  end
endmodule
